// ----- src/sprite_quad_vertex_setup_core_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the sprite quad vertex setup core
// ---------------------------------------------------------------------------
`ifndef SPRITE_QUAD_VERTEX_SETUP_CORE_MACROS_SVH
`define SPRITE_QUAD_VERTEX_SETUP_CORE_MACROS_SVH

// implication checked on every clock, reset masks it
`define SQV_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// next-cycle implication
`define SQV_ASSERT_NXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// ----- src/sqv_pkg.sv -----
// ---------------------------------------------------------------------------
// sqv_pkg
// Shared types and constants for sprite quad vertex setup.
// ---------------------------------------------------------------------------
package sqv_pkg;

    localparam int POS_W    = 24;
    localparam int SCALE_W  = 16;
    localparam int ANGLE_W  = 16;
    localparam int UV_W     = 32;
    localparam int TEX_W    = 16;
    localparam int TRIG_W   = 16;
    localparam int CORDIC_N = 16;
    localparam int TRIG_FB  = 14;

    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_BL = 2'd1;
    localparam logic [1:0] CORNER_BR = 2'd2;
    localparam logic [1:0] CORNER_TR = 2'd3;

    localparam logic signed [31:0] CORDIC_X0 = 32'sd652032874;

    typedef logic signed [33:0] cordic_t;

    function automatic logic signed [15:0] atan_lut(input int i);
        logic signed [15:0] r;
        case (i)
            0: r = 16'sd8192;
            1: r = 16'sd4836;
            2: r = 16'sd2555;
            3: r = 16'sd1297;
            4: r = 16'sd651;
            5: r = 16'sd326;
            6: r = 16'sd163;
            7: r = 16'sd81;
            8: r = 16'sd41;
            9: r = 16'sd20;
            10: r = 16'sd10;
            11: r = 16'sd5;
            12: r = 16'sd3;
            13: r = 16'sd1;
            14: r = 16'sd1;
            default: r = 16'sd0;
        endcase
        return r;
    endfunction

endpackage

// ----- src/sprite_quad_vertex_setup_core.sv -----
// ---------------------------------------------------------------------------
// sprite_quad_vertex_setup_core
// Rotates and scales a sprite rectangle about its pivot and emits the four
// corner vertices with their texture coordinates.
// ---------------------------------------------------------------------------
//  channel | beat                                  | handshake
//  in      | one sprite (dest, origin, scale, ...) | in_valid / in_ready
//  out     | one vertex (pos, tex, corner, last)   | out_valid / out_ready
//
// A sprite passes an input register, a 16-stage CORDIC, one matrix stage, one
// setup stage and the output register, and leaves as four vertex beats, one
// per cycle while out_ready is high. The setup stage takes the next sprite as
// the last corner of the current one enters the output register.
// Every stage holds when the stage after it is full and stalled.
// Reset clears the valid bits and the corner counter only.
// ---------------------------------------------------------------------------
module sprite_quad_vertex_setup_core
#(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 8
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [sqv_pkg::POS_W-1:0]   dest_x,
    input  logic signed [sqv_pkg::POS_W-1:0]   dest_y,
    input  logic signed [sqv_pkg::POS_W-1:0]   dest_w,
    input  logic signed [sqv_pkg::POS_W-1:0]   dest_h,
    input  logic signed [sqv_pkg::POS_W-1:0]   origin_x,
    input  logic signed [sqv_pkg::POS_W-1:0]   origin_y,
    input  logic signed [sqv_pkg::SCALE_W-1:0] scale_x,
    input  logic signed [sqv_pkg::SCALE_W-1:0] scale_y,
    input  logic [sqv_pkg::ANGLE_W-1:0]        angle,
    input  logic [1:0]                        flip,
    input  logic [sqv_pkg::UV_W-1:0]           uv_min,
    input  logic [sqv_pkg::UV_W-1:0]           uv_max,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [sqv_pkg::POS_W-1:0]   pos_x,
    output logic signed [sqv_pkg::POS_W-1:0]   pos_y,
    output logic [sqv_pkg::TEX_W-1:0]          tex_u,
    output logic [sqv_pkg::TEX_W-1:0]          tex_v,
    output logic [1:0]                        corner,
    output logic                              last
);
    import sqv_pkg::*;

    localparam int NS = CORDIC_N;
    localparam int SH = TRIG_FB + FRAC_BITS;
    localparam int LW = POS_W + 1;               // local corner offset
    localparam int MW = TRIG_W + SCALE_W;        // matrix term
    localparam int PW = LW + MW + 2;             // product
    localparam int AW = PW + 2;                  // accumulator
    localparam logic [ANGLE_W-1:0] KEEP =
        ANGLE_W'(16'hFFFF << (ANGLE_W - ANGLE_BITS));

    typedef struct packed {
        logic signed [POS_W-1:0]   dx, dy, dw, dh, ox, oy;
        logic signed [SCALE_W-1:0] sx, sy;
        logic [1:0]                flip;
        logic [UV_W-1:0]           umin, umax;
    } spr_t;

    // ---------------- CORDIC stages ----------------
    logic    cv_reg   [NS+1];
    spr_t    cs_reg   [NS+1];
    cordic_t cx_reg   [NS+1];
    cordic_t cy_reg   [NS+1];
    logic signed [15:0] cz_reg [NS+1];
    logic [1:0] cq_reg [NS+1];
    logic    cr0_reg  [NS+1];
    logic    adv      [NS+1];
    logic    m_adv, p_adv;

    logic    m_v_reg, p_v_reg;
    spr_t    m_s_reg;
    logic signed [MW-1:0] m11_reg, m12_reg, m21_reg, m22_reg;
    logic signed [AW-1:0] tx_reg, ty_reg;

    logic [1:0] k_reg;
    logic signed [LW-1:0] lx0_reg, lx1_reg, ly0_reg, ly1_reg;
    logic signed [MW-1:0] pm11_reg, pm12_reg, pm21_reg, pm22_reg;
    logic signed [AW-1:0] ptx_reg, pty_reg;
    logic [TEX_W-1:0] u0_reg, u1_reg, v0_reg, v1_reg;

    logic signed [POS_W-1:0] pos_x_reg, pos_y_reg;
    logic [TEX_W-1:0] tex_u_reg, tex_v_reg;
    logic [1:0] corner_reg;
    logic last_reg, o_v_reg;

    logic o_take, p_done;
    assign o_take = !o_v_reg || out_ready;
    assign p_done = p_v_reg && o_take && (k_reg == CORNER_TR);
    assign p_adv  = !p_v_reg || p_done;
    assign m_adv  = !m_v_reg || p_adv;

    always_comb
    begin
        adv[NS] = !cv_reg[NS] || m_adv;
        for (int i = NS - 1; i >= 0; i--)
            adv[i] = !cv_reg[i] || adv[i+1];
    end
    assign in_ready = adv[0];

    logic [ANGLE_W-1:0] a_m;
    assign a_m = angle & KEEP;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NS; i++)
                cv_reg[i] <= 1'b0;
        end
        else
        begin
            if (adv[0])
                cv_reg[0] <= in_valid;
            for (int i = 1; i <= NS; i++)
                if (adv[i])
                    cv_reg[i] <= cv_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            cs_reg[0]  <= '{dest_x, dest_y, dest_w, dest_h, origin_x, origin_y,
                           scale_x, scale_y, flip, uv_min, uv_max};
            cx_reg[0]  <= cordic_t'(CORDIC_X0);
            cy_reg[0]  <= '0;
            cz_reg[0]  <= 16'($unsigned(a_m[13:0]));
            cq_reg[0]  <= a_m[15:14];
            cr0_reg[0] <= (a_m[13:0] == 14'd0);
        end
        for (int i = 1; i <= NS; i++)
        begin
            if (adv[i])
            begin
                cs_reg[i]  <= cs_reg[i-1];
                cq_reg[i]  <= cq_reg[i-1];
                cr0_reg[i] <= cr0_reg[i-1];
                if (!cz_reg[i-1][15])
                begin
                    cx_reg[i] <= cx_reg[i-1] - (cy_reg[i-1] >>> (i - 1));
                    cy_reg[i] <= cy_reg[i-1] + (cx_reg[i-1] >>> (i - 1));
                    cz_reg[i] <= cz_reg[i-1] - atan_lut(i - 1);
                end
                else
                begin
                    cx_reg[i] <= cx_reg[i-1] + (cy_reg[i-1] >>> (i - 1));
                    cy_reg[i] <= cy_reg[i-1] - (cx_reg[i-1] >>> (i - 1));
                    cz_reg[i] <= cz_reg[i-1] + atan_lut(i - 1);
                end
            end
        end
    end

    // ---------------- sin/cos finish and matrix ----------------
    cordic_t xr, yr;
    logic signed [TRIG_W-1:0] c0, s0, cc, ss;
    assign xr = (cx_reg[NS] + cordic_t'(32768)) >>> 16;
    assign yr = (cy_reg[NS] + cordic_t'(32768)) >>> 16;

    always_comb
    begin
        if (cr0_reg[NS])
        begin
            c0 = TRIG_W'(1 << TRIG_FB);
            s0 = '0;
        end
        else
        begin
            c0 = xr[TRIG_W-1:0];
            s0 = yr[TRIG_W-1:0];
        end
        case (cq_reg[NS])
            2'd0:    begin cc = c0;  ss = s0;  end
            2'd1:    begin cc = -s0; ss = c0;  end
            2'd2:    begin cc = -c0; ss = -s0; end
            default: begin cc = s0;  ss = -c0; end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_v_reg <= 1'b0;
        else if (m_adv)
            m_v_reg <= cv_reg[NS];
    end

    always_ff @(posedge clk)
    begin
        if (m_adv)
        begin
            m_s_reg <= cs_reg[NS];
            m11_reg <= MW'(cc) * MW'(cs_reg[NS].sx);
            m12_reg <= MW'(ss) * MW'(cs_reg[NS].sy);
            m21_reg <= -(MW'(ss) * MW'(cs_reg[NS].sx));
            m22_reg <= MW'(cc) * MW'(cs_reg[NS].sy);
            tx_reg  <= AW'(cs_reg[NS].dx) <<< SH;
            ty_reg  <= AW'(cs_reg[NS].dy) <<< SH;
        end
    end

    // ---------------- vertex setup stage ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_v_reg <= 1'b0;
            k_reg   <= CORNER_TL;
        end
        else if (p_adv)
        begin
            p_v_reg <= m_v_reg;
            k_reg   <= CORNER_TL;
        end
        else if (p_v_reg && o_take)
            k_reg <= k_reg + 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (p_adv)
        begin
            lx0_reg  <= -LW'(m_s_reg.ox);
            lx1_reg  <= LW'(m_s_reg.dw) - LW'(m_s_reg.ox);
            ly0_reg  <= -LW'(m_s_reg.oy);
            ly1_reg  <= LW'(m_s_reg.dh) - LW'(m_s_reg.oy);
            pm11_reg <= m11_reg;
            pm12_reg <= m12_reg;
            pm21_reg <= m21_reg;
            pm22_reg <= m22_reg;
            ptx_reg  <= tx_reg;
            pty_reg  <= ty_reg;
            u0_reg   <= m_s_reg.flip[0] ? m_s_reg.umax[15:0]  : m_s_reg.umin[15:0];
            u1_reg   <= m_s_reg.flip[0] ? m_s_reg.umin[15:0]  : m_s_reg.umax[15:0];
            v0_reg   <= m_s_reg.flip[1] ? m_s_reg.umax[31:16] : m_s_reg.umin[31:16];
            v1_reg   <= m_s_reg.flip[1] ? m_s_reg.umin[31:16] : m_s_reg.umax[31:16];
        end
    end

    logic sel_x, sel_y;
    logic signed [LW-1:0] lx, ly;
    logic signed [AW-1:0] ax, ay, rx, ry;
    assign sel_x = (k_reg == CORNER_BR) || (k_reg == CORNER_TR);
    assign sel_y = (k_reg == CORNER_BL) || (k_reg == CORNER_BR);
    assign lx = sel_x ? lx1_reg : lx0_reg;
    assign ly = sel_y ? ly1_reg : ly0_reg;
    assign ax = AW'(lx) * AW'(pm11_reg) + AW'(ly) * AW'(pm12_reg) + ptx_reg
              + (AW'(1) <<< (SH - 1));
    assign ay = AW'(lx) * AW'(pm21_reg) + AW'(ly) * AW'(pm22_reg) + pty_reg
              + (AW'(1) <<< (SH - 1));
    assign rx = ax >>> SH;
    assign ry = ay >>> SH;

    function automatic logic signed [POS_W-1:0] sat(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] hi, lo;
        hi = AW'(8388607);
        lo = -AW'(8388608);
        if (v > hi)
            return POS_W'(hi);
        else if (v < lo)
            return POS_W'(lo);
        return v[POS_W-1:0];
    endfunction

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_v_reg <= 1'b0;
        else if (o_take)
            o_v_reg <= p_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (o_take && p_v_reg)
        begin
            pos_x_reg  <= sat(rx);
            pos_y_reg  <= sat(ry);
            tex_u_reg  <= sel_x ? u1_reg : u0_reg;
            tex_v_reg  <= sel_y ? v1_reg : v0_reg;
            corner_reg <= k_reg;
            last_reg   <= (k_reg == CORNER_TR);
        end
    end

    assign out_valid = o_v_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign tex_u     = tex_u_reg;
    assign tex_v     = tex_v_reg;
    assign corner    = corner_reg;
    assign last      = last_reg;

endmodule

// ----- src/sqv_checker.sv -----
// ---------------------------------------------------------------------------
// sqv_checker
// Port-level checks on sprite quad vertex order, last flag and stall hold.
// ---------------------------------------------------------------------------
`include "sprite_quad_vertex_setup_core_macros.svh"

module sqv_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] corner,
    input logic       last
);
    import sqv_pkg::*;

    logic beat;
    assign beat = out_valid && out_ready;

    `SQV_ASSERT_IMP(a_last_corner, clk, rst_n, out_valid, last == (corner == CORNER_TR), "last mismatch")
    `SQV_ASSERT_NXT(a_order, clk, rst_n, beat && !last, !out_valid || corner == $past(corner) + 2'd1, "corner order")
    `SQV_ASSERT_NXT(a_first, clk, rst_n, beat && last, !out_valid || corner == CORNER_TL, "sprite start")
    `SQV_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(corner), "stall hold")

endmodule

bind sprite_quad_vertex_setup_core sqv_checker u_sqv_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .corner    (corner),
    .last      (last)
);

// ----- tb/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// Drives sprites into the quad vertex setup core with bursty input and a
// stalling output, predicts the four corner vertices of every later sprite
// in a local fixed-point CORDIC model and checks every vertex beat in order.
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sqv_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [23:0] dx, dy, dw, dh, ox, oy;
        logic signed [15:0] sx, sy;
        logic [15:0]        ang;
        logic [1:0]         flp;
        logic [31:0]        uvlo, uvhi;
    } sprite_t;

    typedef struct {
        logic signed [23:0] px, py;
        logic [15:0]        u, v;
        logic [1:0]         crn;
        logic               lst;
    } vertex_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0, in_ready;
    logic signed [23:0] dest_x = '0, dest_y = '0, dest_w = '0, dest_h = '0;
    logic signed [23:0] origin_x = '0, origin_y = '0;
    logic signed [15:0] scale_x = '0, scale_y = '0;
    logic [15:0] angle = '0;
    logic [1:0]  flip = '0;
    logic [31:0] uv_min = '0, uv_max = '0;
    logic out_valid, out_ready = 1'b0;
    logic signed [23:0] pos_x, pos_y;
    logic [15:0] tex_u, tex_v;
    logic [1:0]  corner;
    logic        last;

    vertex_t pending_verts[$];
    int      errors = 0;
    int      cycles = 0;
    bit      stim_done = 0;

    sprite_quad_vertex_setup_core dut (.*);

    initial begin
        forever #6 clk = ~clk;
    end

    function automatic longint floor_shr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic void trig_q14(logic [15:0] a, output longint sn, output longint cs);
        longint x, y, z, dxx, dyy, c0, s0;
        int     tab[16];
        tab = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
        z = longint'(a[13:0]);
        if (z == 0)
        begin
            c0 = 16384;
            s0 = 0;
        end
        else
        begin
            x = 652032874;
            y = 0;
            for (int i = 0; i < 16; i++)
            begin
                dxx = floor_shr(y, i);
                dyy = floor_shr(x, i);
                if (z >= 0)
                begin
                    x -= dxx; y += dyy; z -= tab[i];
                end
                else
                begin
                    x += dxx; y -= dyy; z += tab[i];
                end
            end
            c0 = floor_shr(x + 32768, 16);
            s0 = floor_shr(y + 32768, 16);
        end
        case (a[15:14])
            2'd0: begin cs = c0;  sn = s0;  end
            2'd1: begin cs = -s0; sn = c0;  end
            2'd2: begin cs = -c0; sn = -s0; end
            default: begin cs = s0; sn = -c0; end
        endcase
    endfunction

    function automatic logic signed [23:0] round_sat(longint acc);
        longint v;
        v = floor_shr(acc + (64'sd1 <<< 21), 22);
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return v[23:0];
    endfunction

    task automatic predict_quad(sprite_t sp);
        longint sn, cs, m11, m12, m21, m22, tx, ty, lx, ly;
        longint lxs[2], lys[2];
        logic [15:0] umin, umax, vmin, vmax;
        logic [1:0] crn_tab[4];
        vertex_t vt;
        crn_tab = '{CORNER_TL, CORNER_BL, CORNER_BR, CORNER_TR};
        trig_q14(sp.ang, sn, cs);
        m11 = cs * longint'(sp.sx);
        m12 = sn * longint'(sp.sy);
        m21 = -sn * longint'(sp.sx);
        m22 = cs * longint'(sp.sy);
        tx = longint'(sp.dx) <<< 22;
        ty = longint'(sp.dy) <<< 22;
        lxs[0] = -longint'(sp.ox);
        lxs[1] = longint'(sp.dw) - longint'(sp.ox);
        lys[0] = -longint'(sp.oy);
        lys[1] = longint'(sp.dh) - longint'(sp.oy);
        umin = sp.uvlo[15:0];  vmin = sp.uvlo[31:16];
        umax = sp.uvhi[15:0];  vmax = sp.uvhi[31:16];
        if (sp.flp[0]) begin umin = sp.uvhi[15:0];  umax = sp.uvlo[15:0];  end
        if (sp.flp[1]) begin vmin = sp.uvhi[31:16]; vmax = sp.uvlo[31:16]; end
        for (int k = 0; k < 4; k++)
        begin
            lx = lxs[k >= 2];
            ly = lys[k == 1 || k == 2];
            vt.px = round_sat(lx * m11 + ly * m12 + tx);
            vt.py = round_sat(lx * m21 + ly * m22 + ty);
            vt.u = (k >= 2) ? umax : umin;
            vt.v = (k == 1 || k == 2) ? vmax : vmin;
            vt.crn = crn_tab[k];
            vt.lst = (crn_tab[k] == CORNER_TR);
            pending_verts.insert(pending_verts.size(), vt);
        end
    endtask

    function automatic sprite_t rand_sprite();
        sprite_t sp;
        int mode;
        mode = $urandom_range(0, 9);
        sp.dx = 24'($urandom); sp.dy = 24'($urandom);
        sp.uvlo = $urandom; sp.uvhi = $urandom;
        sp.ang = 16'($urandom);
        sp.flp = 2'($urandom);
        if (mode < 6)
        begin
            sp.dx = 24'($urandom_range(0, 1 << 18) - (1 << 17));
            sp.dy = 24'($urandom_range(0, 1 << 18) - (1 << 17));
            sp.dw = 24'($urandom_range(0, 1 << 16));
            sp.dh = 24'($urandom_range(0, 1 << 16));
            sp.ox = 24'($urandom_range(0, 1 << 16) - (1 << 15));
            sp.oy = 24'($urandom_range(0, 1 << 16) - (1 << 15));
            sp.sx = 16'($urandom_range(0, 2048) - 1024);
            sp.sy = 16'($urandom_range(0, 2048) - 1024);
            sp.uvlo = {1'b0, 15'($urandom), 1'b0, 15'($urandom)};
            sp.uvhi = {1'b0, 15'($urandom), 1'b0, 15'($urandom)};
            if (mode == 0) sp.ang[13:0] = '0;
        end
        else
        begin
            sp.dw = 24'($urandom); sp.dh = 24'($urandom);
            sp.ox = 24'($urandom); sp.oy = 24'($urandom);
            sp.sx = 16'($urandom); sp.sy = 16'($urandom);
        end
        return sp;
    endfunction

    task automatic send_sprite(sprite_t sp);
        dest_x <= sp.dx; dest_y <= sp.dy; dest_w <= sp.dw; dest_h <= sp.dh;
        origin_x <= sp.ox; origin_y <= sp.oy;
        scale_x <= sp.sx; scale_y <= sp.sy;
        angle <= sp.ang; flip <= sp.flp;
        uv_min <= sp.uvlo; uv_max <= sp.uvhi;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        predict_quad(sp);
        @(negedge clk);
    endtask

    // directed rows: identity sprite has hand-typed corners
    initial begin
        sprite_t rows[$];
        sprite_t sp;
        vertex_t id_verts[$];
        int      burst;
        int      gap;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        sp = '{24'sd256, 24'sd512, 24'sd1024, 24'sd2048, 24'sd0, 24'sd0,
               16'sd256, 16'sd256, 16'd0, 2'd0, 32'h2000_1000, 32'h4000_3000};
        rows.insert(rows.size(), sp);
        sp.flp = 2'd3; rows.insert(rows.size(), sp);
        sp.flp = 2'd1; sp.ang = 16'h4000; rows.insert(rows.size(), sp);
        sp.flp = 2'd2; sp.ang = 16'h8000; rows.insert(rows.size(), sp);
        sp.ang = 16'hC000; rows.insert(rows.size(), sp);
        sp.ang = 16'h2000; sp.ox = 24'sd512; sp.oy = 24'sd1024; rows.insert(rows.size(), sp);
        sp.ang = 16'h0001; rows.insert(rows.size(), sp);
        sp.ang = 16'hFFFF; sp.sx = 16'sh8000; sp.sy = 16'sh7FFF; rows.insert(rows.size(), sp);
        sp = '{24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh800000,
               24'sh7FFFFF, 16'sh7FFF, 16'sh7FFF, 16'h1234, 2'd3,
               32'hFFFF_FFFF, 32'h0000_0000};
        rows.insert(rows.size(), sp);
        sp.dx = 24'sh800000; sp.dy = 24'sh7FFFFF; sp.sx = 16'sh8000; sp.ang = 16'h5555;
        rows.insert(rows.size(), sp);
        sp = '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'sd0, 16'sd0,
               16'h00FF, 2'd0, 32'h8001_8000, 32'h8000_8001};
        rows.insert(rows.size(), sp);
        sp.ang = 16'hAAAA; sp.sx = 16'sh8000; sp.sy = 16'sh8000; sp.dw = 24'sh800000;
        rows.insert(rows.size(), sp);

        id_verts = '{'{24'sd256, 24'sd512, 16'h1000, 16'h2000, CORNER_TL, 1'b0},
                     '{24'sd256, 24'sd2560, 16'h1000, 16'h4000, CORNER_BL, 1'b0},
                     '{24'sd1280, 24'sd2560, 16'h3000, 16'h4000, CORNER_BR, 1'b0},
                     '{24'sd1280, 24'sd512, 16'h3000, 16'h2000, CORNER_TR, 1'b1}};

        @(negedge clk);
        dest_x <= rows[0].dx; dest_y <= rows[0].dy; dest_w <= rows[0].dw;
        dest_h <= rows[0].dh; origin_x <= rows[0].ox; origin_y <= rows[0].oy;
        scale_x <= rows[0].sx; scale_y <= rows[0].sy; angle <= rows[0].ang;
        flip <= rows[0].flp; uv_min <= rows[0].uvlo; uv_max <= rows[0].uvhi;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        foreach (id_verts[i]) pending_verts.insert(pending_verts.size(), id_verts[i]);
        @(negedge clk);
        for (int i = 1; i < rows.size(); i++) send_sprite(rows[i]);

        for (int n = 0; n < 260; )
        begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && n < 260; b++, n++) send_sprite(rand_sprite());
            gap = $urandom_range(0, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        in_valid <= 1'b0;
        stim_done = 1;
    end

    // output stall pattern
    initial begin
        int mode;
        forever
        begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(4, 40))
            begin
                @(negedge clk);
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 3) != 0);
                    2: out_ready <= 1'($urandom);
                    default: out_ready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        vertex_t ev;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_verts.size() == 0)
            begin
                $error("unexpected vertex beat");
                errors++;
            end
            else
            begin
                ev = pending_verts.pop_front();
                if (pos_x !== ev.px)
                begin
                    $error("pos_x exp %0d got %0d", ev.px, pos_x); errors++;
                end
                if (pos_y !== ev.py)
                begin
                    $error("pos_y exp %0d got %0d", ev.py, pos_y); errors++;
                end
                if (tex_u !== ev.u)
                begin
                    $error("tex_u exp %0h got %0h", ev.u, tex_u); errors++;
                end
                if (tex_v !== ev.v)
                begin
                    $error("tex_v exp %0h got %0h", ev.v, tex_v); errors++;
                end
                if (corner !== ev.crn)
                begin
                    $error("corner exp %0d got %0d", ev.crn, corner); errors++;
                end
                if (last !== ev.lst)
                begin
                    $error("last exp %0d got %0d", ev.lst, last); errors++;
                end
            end
        end
    end

    initial begin
        wait (stim_done && pending_verts.size() == 0);
        repeat (40) @(posedge clk);
        if (errors == 0 && pending_verts.size() == 0)
            $display("sprite_quad_vertex_setup_core: match");
        else
            $display("sprite_quad_vertex_setup_core: mismatch");
        $finish;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("sprite_quad_vertex_setup_core: mismatch");
            $finish;
        end
    end
endmodule

// ----- sprite_quad_vertex_setup_core.f -----
+incdir+src
src/sqv_pkg.sv
src/sprite_quad_vertex_setup_core.sv
src/sqv_checker.sv
tb/tb_top.sv
